// ===== rtl/rlsd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlsd_pkg
// Types and constants shared by the run-length line sprite decoder.
// ----------------------------------------------------------------------------
package rlsd_pkg;

  localparam int unsigned FRAME_BYTES = 524288;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 11;

  localparam logic [CFG_INDEX_W-1:0] CFG_ORIGIN_X   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ORIGIN_Y   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_LINE_COUNT = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_ROW_PITCH  = 2'd3;

  localparam logic [10:0] ROW_PITCH_RESET = 11'd320;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       object_start;
  } in_t;

  typedef struct packed {
    logic        write_enable;
    logic [18:0] write_address;
    logic [7:0]  run_length;
    logic [7:0]  pixel_value;
    logic        object_done;
    logic        range_error;
  } out_t;

  typedef struct packed {
    logic [9:0]  origin_x;
    logic [9:0]  origin_y;
    logic [9:0]  line_count;
    logic [10:0] row_pitch;
  } cfg_t;

endpackage

// ===== rtl/rlsd_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlsd_core
// Decoder state and the single-step update for one coded byte.
// ----------------------------------------------------------------------------
module rlsd_core
  import rlsd_pkg::*;
#(
  parameter int unsigned FrameBytes = FRAME_BYTES
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic step_i,
  input  cfg_t cfg_i,
  input  in_t  req_i,
  output out_t res_o
);

  localparam logic [2:0] PhCntLo   = 3'd0;
  localparam logic [2:0] PhCntHi   = 3'd1;
  localparam logic [2:0] PhCode    = 3'd2;
  localparam logic [2:0] PhFillVal = 3'd3;
  localparam logic [2:0] PhLiteral = 3'd4;
  localparam logic [2:0] PhIdle    = 3'd5;

  localparam logic [20:0] PtrCap = 21'h100000;

  logic [2:0]  phase_q, phase_d;
  logic [15:0] lbl_q, lbl_d;
  logic [7:0]  cnt_lo_q, cnt_lo_d;
  logic [7:0]  lit_q, lit_d;
  logic [7:0]  fill_q, fill_d;
  logic [9:0]  line_q, line_d;
  logic [20:0] ptr_q, ptr_d;

  logic [2:0]  ph_eff;
  logic [9:0]  line_eff;
  logic [9:0]  line_next;
  logic        last_line;
  logic [21:0] base_addr;
  logic [22:0] start_addr;
  logic [20:0] start_ptr;
  logic [7:0]  run_len;
  logic [21:0] run_end;
  logic [20:0] ptr_adv;
  logic        run_fits;
  logic [15:0] lbl_m1;
  logic [7:0]  code_len;
  logic [15:0] lbl_code;
  logic [7:0]  lit_m1;
  logic [15:0] line_bytes;
  logic        do_emit;
  logic        do_end;
  logic [7:0]  b;

  always_comb begin
    b          = req_i.data_byte;
    ph_eff     = req_i.object_start ? PhCntLo : phase_q;
    line_eff   = req_i.object_start ? '0 : line_q;
    line_next  = line_eff + 10'd1;
    last_line  = line_next >= cfg_i.line_count;
    base_addr  = 22'(({1'b0, cfg_i.origin_y} + {1'b0, line_eff}) * cfg_i.row_pitch);
    start_addr = {1'b0, base_addr} + 23'(cfg_i.origin_x);
    start_ptr  = (start_addr > 23'(PtrCap)) ? PtrCap : start_addr[20:0];
    run_len    = (ph_eff == PhFillVal) ? fill_q : 8'd1;
    run_end    = {1'b0, ptr_q} + 22'(run_len);
    ptr_adv    = (run_end > 22'(PtrCap)) ? PtrCap : run_end[20:0];
    run_fits   = run_end <= 22'(FrameBytes);
    lbl_m1     = (lbl_q != '0) ? lbl_q - 16'd1 : '0;
    code_len   = {1'b0, b[7:1]} + 8'd1;
    lbl_code   = (lbl_m1 > 16'(code_len)) ? lbl_m1 - 16'(code_len) : '0;
    lit_m1     = (lit_q != '0) ? lit_q - 8'd1 : '0;
    line_bytes = {b, cnt_lo_q};

    phase_d  = ph_eff;
    lbl_d    = lbl_q;
    cnt_lo_d = cnt_lo_q;
    lit_d    = lit_q;
    fill_d   = fill_q;
    line_d   = line_eff;
    ptr_d    = ptr_q;
    do_emit  = 1'b0;
    do_end   = 1'b0;

    unique case (ph_eff)
      PhCntLo: begin
        if (line_eff >= cfg_i.line_count) begin
          phase_d = PhIdle;
        end else begin
          cnt_lo_d = b;
          phase_d  = PhCntHi;
        end
      end
      PhCntHi: begin
        lbl_d = line_bytes;
        ptr_d = start_ptr;
        if (line_bytes == '0) begin
          do_end = 1'b1;
        end else begin
          phase_d = PhCode;
        end
      end
      PhCode: begin
        if (b[0]) begin
          lbl_d   = lbl_m1;
          fill_d  = code_len;
          phase_d = PhFillVal;
        end else begin
          lbl_d   = lbl_code;
          lit_d   = code_len;
          phase_d = PhLiteral;
        end
      end
      PhFillVal: begin
        lbl_d   = lbl_m1;
        do_emit = 1'b1;
        ptr_d   = ptr_adv;
        if (lbl_m1 == '0) begin
          do_end = 1'b1;
        end else begin
          phase_d = PhCode;
        end
      end
      PhLiteral: begin
        do_emit = 1'b1;
        ptr_d   = ptr_adv;
        lit_d   = lit_m1;
        if (lit_m1 == '0) begin
          if (lbl_q == '0) begin
            do_end = 1'b1;
          end else begin
            phase_d = PhCode;
          end
        end
      end
      default: begin
        phase_d = PhIdle;
      end
    endcase

    res_o = '0;
    if (do_end) begin
      line_d            = line_next;
      phase_d           = last_line ? PhIdle : PhCntLo;
      res_o.object_done = last_line;
    end
    if (do_emit && (b != '0)) begin
      if (!run_fits) begin
        res_o.range_error = 1'b1;
      end else begin
        res_o.write_enable  = 1'b1;
        res_o.write_address = ptr_q[18:0];
        res_o.run_length    = run_len;
        res_o.pixel_value   = b;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhCntLo;
      lbl_q    <= '0;
      cnt_lo_q <= '0;
      lit_q    <= '0;
      fill_q   <= '0;
      line_q   <= '0;
      ptr_q    <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      lbl_q    <= lbl_d;
      cnt_lo_q <= cnt_lo_d;
      lit_q    <= lit_d;
      fill_q   <= fill_d;
      line_q   <= line_d;
      ptr_q    <= ptr_d;
    end
  end

endmodule

// ===== rtl/rle_line_sprite_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_line_sprite_decoder
// Decodes a run-length coded line sprite byte stream into pixel run writes.
// ----------------------------------------------------------------------------
//   channel  | direction | handshake               | payload
//   request  | in        | in_valid_i / in_stall_o | in_req_i (in_t)
//   result   | out       | out_valid_o/out_stall_i | out_res_o (out_t)
//   config   | in        | cfg_we_i                | cfg_index_i, cfg_data_i
//
// Every request produces exactly one result; one request per cycle is sustained
// while the result is not stalled. A request is captured in the input register,
// then decoded in a single step into the result register. The row start
// multiply and the run bounds check set the path.
// Reset clears the decoder state and loads the register reset values.
// A stalled result holds the input register; a new request is still taken
// while the input register is empty or moving on.
module rle_line_sprite_decoder
  import rlsd_pkg::*;
#(
  parameter int unsigned FrameBytes = FRAME_BYTES
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  in_t                    in_req_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output out_t                   out_res_o,
  input  logic                   cfg_we_i,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  cfg_t cfg_q;
  in_t  in_q;
  logic in_vld_q;
  out_t out_q;
  logic out_vld_q;
  out_t res;
  logic advance;
  logic in_acc;

  assign advance    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && out_vld_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.origin_x   <= '0;
      cfg_q.origin_y   <= '0;
      cfg_q.line_count <= '0;
      cfg_q.row_pitch  <= ROW_PITCH_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_ORIGIN_X:   cfg_q.origin_x   <= cfg_data_i[9:0];
        CFG_ORIGIN_Y:   cfg_q.origin_y   <= cfg_data_i[9:0];
        CFG_LINE_COUNT: cfg_q.line_count <= cfg_data_i[9:0];
        CFG_ROW_PITCH:  cfg_q.row_pitch  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_acc || (in_vld_q && !advance);
      out_vld_q <= advance || (out_vld_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_q <= in_req_i;
    end
    if (advance) begin
      out_q <= res;
    end
  end

  rlsd_core #(
    .FrameBytes(FrameBytes)
  ) u_core (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(advance),
    .cfg_i (cfg_q),
    .req_i (in_q),
    .res_o (res)
  );

  assign out_valid_o = out_vld_q;
  assign out_res_o   = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_res_o.write_enable && out_res_o.range_error))
    else $error("write issued together with a range error");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_res_o.write_enable) |->
      (out_res_o.write_address == '0 && out_res_o.run_length == '0 &&
       out_res_o.pixel_value == '0))
    else $error("idle result carries a nonzero payload");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_res_o.write_enable) |->
      (out_res_o.run_length != '0 && out_res_o.run_length <= 8'd128 &&
       out_res_o.pixel_value != '0))
    else $error("write with bad run length or transparent value");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_vld_q)
    else $error("decoded request lost before the result register");

endmodule
